>>> sv/b64sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64sc_pkg;

  // results one item can cause at most
  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] CharPad = 8'h3D;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // item class, chosen by the front part
  typedef enum logic [1:0] {
    K_ENC_BYTE,
    K_DEC_VAL,
    K_DEC_PAD,
    K_DEC_BAD
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;   // raw byte, or 6-bit value in the low bits
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       valid;
    logic       last;
    logic       error;
  } res_t;

  // queue side of the front/back link
  typedef struct packed {
    logic push;
  } qctl_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'h41;
    end else if (v < 6'd52) begin
      c = w + 8'h47;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic res_t mk_res(input logic [7:0] sym, input logic valid,
                                  input logic last, input logic error);
    res_t r;
    r.symbol = sym;
    r.valid  = valid;
    r.last   = last;
    r.error  = error;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/b64sc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_fire_i,
  input  wire logic            cfg_data_i,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_symbol_i,
  input  wire logic            in_last_i,
  output      logic            in_stall_o,
  input  wire logic            q_full_i,
  output      b64sc_pkg::qctl_t qctl_o,
  output      b64sc_pkg::cmd_t cmd_o
);
  import b64sc_pkg::*;

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
    end else if (cfg_fire_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // character classification
  always_comb begin
    cmd_o.last = in_last_i;
    cmd_o.data = in_symbol_i;
    cmd_o.kind = K_ENC_BYTE;
    if (mode_q == ModeDecode) begin
      cmd_o.kind = K_DEC_VAL;
      if (in_symbol_i >= 8'h41 && in_symbol_i <= 8'h5A) begin
        cmd_o.data = in_symbol_i - 8'h41;
      end else if (in_symbol_i >= 8'h61 && in_symbol_i <= 8'h7A) begin
        cmd_o.data = in_symbol_i - 8'h47;
      end else if (in_symbol_i >= 8'h30 && in_symbol_i <= 8'h39) begin
        cmd_o.data = in_symbol_i + 8'd4;
      end else if (in_symbol_i == 8'h2B) begin
        cmd_o.data = 8'd62;
      end else if (in_symbol_i == 8'h2F) begin
        cmd_o.data = 8'd63;
      end else if (in_symbol_i == CharPad) begin
        cmd_o.kind = K_DEC_PAD;
        cmd_o.data = '0;
      end else begin
        cmd_o.kind = K_DEC_BAD;
        cmd_o.data = '0;
      end
    end
  end

  assign in_stall_o  = q_full_i;
  assign qctl_o.push = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

>>> sv/b64sc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64sc_pkg::cmd_t wdata_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      b64sc_pkg::cmd_t rdata_o
);
  import b64sc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/b64sc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64sc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clr_i,
  input  wire logic            q_empty_i,
  input  wire b64sc_pkg::cmd_t cmd_i,
  output      logic            q_pop_o,
  output      logic            res_valid_o,
  input  wire logic            res_stall_i,
  output      b64sc_pkg::res_t res_o
);
  import b64sc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRes + 1);
  localparam int unsigned IdxW = $clog2(MaxRes);

  logic [5:0]      held_q, held_d;
  logic [1:0]      phase_q, phase_d;
  res_t            buf_q [MaxRes];
  res_t            bun [MaxRes];
  logic [CntW-1:0] cnt_q, bcnt;
  logic [IdxW-1:0] idx_q;
  logic            res_valid_q;
  res_t            res_q;
  logic            out_free;
  logic [7:0]      b;
  logic [5:0]      v;

  assign out_free    = !res_valid_q || !res_stall_i;
  assign q_pop_o     = !q_empty_i &&
                       ((cnt_q == '0) || ((cnt_q == CntW'(1)) && out_free));
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign b           = cmd_i.data;
  assign v           = cmd_i.data[5:0];

  // results and next state for the item at the queue head
  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      bun[i] = '0;
    end
    bcnt    = '0;
    held_d  = held_q;
    phase_d = phase_q;
    unique case (cmd_i.kind)
      K_ENC_BYTE: begin
        case (phase_q)
          2'd1: begin
            bun[0]  = mk_res(enc_char(held_q | {2'b00, b[7:4]}), 1'b1, 1'b0, 1'b0);
            held_d  = {b[3:0], 2'b00};
            phase_d = 2'd2;
            bcnt    = CntW'(1);
            if (cmd_i.last) begin
              bun[1] = mk_res(enc_char({b[3:0], 2'b00}), 1'b1, 1'b0, 1'b0);
              bun[2] = mk_res(CharPad, 1'b1, 1'b1, 1'b0);
              bcnt   = CntW'(3);
            end
          end
          2'd2: begin
            bun[0]  = mk_res(enc_char(held_q | {4'b0000, b[7:6]}), 1'b1, 1'b0, 1'b0);
            bun[1]  = mk_res(enc_char(b[5:0]), 1'b1, cmd_i.last, 1'b0);
            held_d  = '0;
            phase_d = 2'd0;
            bcnt    = CntW'(2);
          end
          default: begin
            // phase three does not arise here and acts as phase zero
            bun[0]  = mk_res(enc_char(b[7:2]), 1'b1, 1'b0, 1'b0);
            held_d  = {b[1:0], 4'b0000};
            phase_d = 2'd1;
            bcnt    = CntW'(1);
            if (cmd_i.last) begin
              bun[1] = mk_res(enc_char({b[1:0], 4'b0000}), 1'b1, 1'b0, 1'b0);
              bun[2] = mk_res(CharPad, 1'b1, 1'b0, 1'b0);
              bun[3] = mk_res(CharPad, 1'b1, 1'b1, 1'b0);
              bcnt   = CntW'(4);
            end
          end
        endcase
      end
      K_DEC_VAL: begin
        case (phase_q)
          2'd0: begin
            held_d  = v;
            phase_d = 2'd1;
          end
          2'd1: begin
            bun[0]  = mk_res({held_q, v[5:4]}, 1'b1, cmd_i.last, 1'b0);
            held_d  = {2'b00, v[3:0]};
            phase_d = 2'd2;
            bcnt    = CntW'(1);
          end
          2'd2: begin
            bun[0]  = mk_res({held_q[3:0], v[5:2]}, 1'b1, cmd_i.last, 1'b0);
            held_d  = {4'b0000, v[1:0]};
            phase_d = 2'd3;
            bcnt    = CntW'(1);
          end
          default: begin
            bun[0]  = mk_res({held_q[1:0], v}, 1'b1, cmd_i.last, 1'b0);
            held_d  = '0;
            phase_d = 2'd0;
            bcnt    = CntW'(1);
          end
        endcase
      end
      K_DEC_PAD: begin
        // padding is skipped
      end
      K_DEC_BAD: begin
        bun[0] = mk_res(8'h00, 1'b0, cmd_i.last, 1'b1);
        bcnt   = CntW'(1);
      end
      default: begin
      end
    endcase
    // end of a decoded stream: bare end marker if nothing else went out
    if (cmd_i.kind != K_ENC_BYTE && cmd_i.last) begin
      if (bcnt == '0) begin
        bun[0] = mk_res(8'h00, 1'b0, 1'b1, 1'b0);
        bcnt   = CntW'(1);
      end
    end
    if (cmd_i.last) begin
      held_d  = '0;
      phase_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        held_q  <= '0;
        phase_q <= '0;
      end else if (q_pop_o) begin
        held_q  <= held_d;
        phase_q <= phase_d;
      end
      if (out_free) begin
        res_valid_q <= (cnt_q != '0);
      end
      if (q_pop_o) begin
        cnt_q <= bcnt;
        idx_q <= '0;
      end else if (out_free && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && cnt_q != '0) begin
      res_q <= buf_q[idx_q];
    end
    if (q_pop_o) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_q[i] <= bun[i];
      end
    end
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRes))
    else $error("result count beyond bundle size");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + (IdxW + 1)'(cnt_q)) <= (IdxW + 1)'(MaxRes))
    else $error("result index runs past bundle");

  a_err_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.error) |-> (!res_q.valid && res_q.symbol == 8'h00))
    else $error("error result carries data");

  a_clr_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (phase_q == 2'd0 && held_q == 6'd0))
    else $error("mode write left group state");

endmodule

`default_nettype wire

>>> sv/base64_stream_codec_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 codec, standard alphabet with '=' padding. cfg_data_i
// picks the mode (0 encode bytes, 1 decode characters); a write clears the
// group state and must only come while the block is idle. Input items go
// through a classifier into a small queue (FifoDepth entries), and a back
// sequencer turns each item into its results, one result per cycle through
// an output register while res_stall_i is low. The input side takes one item
// per cycle while the queue has room. The back sequencer takes the next item
// as the last result goes out. Encoding gives one or two characters per byte
// (up to four on the last byte), decoding at most one byte per character, so
// long encode streams give 4 characters per 3 bytes. in_stall_o rises only
// when the queue is full. A decode stream's last item always gives at least
// one result (a bare end marker with out_valid_o low when nothing else).
module base64_stream_codec_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write channel
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic       cfg_data_i,
  // input items
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] in_symbol_i,
  input  wire logic       in_last_i,
  // result items
  output      logic       res_valid_o,
  input  wire logic       res_stall_i,
  output      logic [7:0] out_symbol_o,
  output      logic       out_valid_o,
  output      logic       out_last_o,
  output      logic       out_error_o
);
  import b64sc_pkg::*;

  logic  cfg_fire;
  qctl_t qctl;
  cmd_t  cmd_in, cmd_head;
  logic  q_full, q_empty, q_pop;
  res_t  res;

  // register writes are always taken in one transfer
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // front: mode register, character classification, input handshake
  b64sc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_fire_i (cfg_fire),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_symbol_i(in_symbol_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .qctl_o     (qctl),
    .cmd_o      (cmd_in)
  );

  // decoupling queue of classified items
  b64sc_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (qctl.push),
    .wdata_i(cmd_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(cmd_head)
  );

  // back: group state, result bundle, output register
  b64sc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (cfg_fire),
    .q_empty_i  (q_empty),
    .cmd_i      (cmd_head),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid_o),
    .res_stall_i(res_stall_i),
    .res_o      (res)
  );

  assign out_symbol_o = res.symbol;
  assign out_valid_o  = res.valid;
  assign out_last_o   = res.last;
  assign out_error_o  = res.error;

endmodule

`default_nettype wire

>>> tb/sv/codec_result_check.sv
`timescale 1ns / 1ps

module codec_result_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_symbol_i,
  input  logic       in_last_i,
  input  logic       res_valid_i,
  input  logic       res_stall_i,
  input  logic [7:0] out_symbol_i,
  input  logic       out_valid_i,
  input  logic       out_last_i,
  input  logic       out_error_i,
  output int         pending_o,
  output int         fail_count_o
);

  import b64sc_pkg::*;

  string digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // shadow of the codec state
  logic       mode_q;
  logic [5:0] carry_bits;
  logic [1:0] group_pos;

  res_t owed_results[$];
  int   mismatches;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return digits[v];
  endfunction

  // 64 flags a character outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] idx;
    idx = 7'd64;
    for (int k = 0; k < 64; k++) begin
      if (digits[k] == c) begin
        idx = 7'(k);
      end
    end
    return idx;
  endfunction

  task automatic owe(input logic [7:0] sym, input logic valid, input logic last,
                     input logic error);
    res_t r;
    r.symbol = sym;
    r.valid  = valid;
    r.last   = last;
    r.error  = error;
    owed_results.insert(owed_results.size(), r);
  endtask

  task automatic predict_codec_results(input logic [7:0] b, input logic last);
    int         made;
    logic [6:0] v;
    made = owed_results.size();
    if (mode_q == ModeEncode) begin
      if (group_pos == 2'd1) begin
        owe(sextet_char(carry_bits | {2'b00, b[7:4]}), 1'b1, 1'b0, 1'b0);
        carry_bits = {b[3:0], 2'b00};
        group_pos  = 2'd2;
        if (last) begin
          owe(sextet_char(carry_bits), 1'b1, 1'b0, 1'b0);
          owe(CharPad, 1'b1, 1'b1, 1'b0);
        end
      end else if (group_pos == 2'd2) begin
        owe(sextet_char(carry_bits | {4'b0000, b[7:6]}), 1'b1, 1'b0, 1'b0);
        owe(sextet_char(b[5:0]), 1'b1, last, 1'b0);
        carry_bits = '0;
        group_pos  = 2'd0;
      end else begin
        owe(sextet_char(b[7:2]), 1'b1, 1'b0, 1'b0);
        carry_bits = {b[1:0], 4'b0000};
        group_pos  = 2'd1;
        if (last) begin
          owe(sextet_char(carry_bits), 1'b1, 1'b0, 1'b0);
          owe(CharPad, 1'b1, 1'b0, 1'b0);
          owe(CharPad, 1'b1, 1'b1, 1'b0);
        end
      end
    end else begin
      v = char_sextet(b);
      if (b == CharPad) begin
        // padding is skipped
      end else if (v[6]) begin
        owe(8'h00, 1'b0, last, 1'b1);
      end else if (group_pos == 2'd0) begin
        carry_bits = v[5:0];
        group_pos  = 2'd1;
      end else if (group_pos == 2'd1) begin
        owe({carry_bits, v[5:4]}, 1'b1, last, 1'b0);
        carry_bits = {2'b00, v[3:0]};
        group_pos  = 2'd2;
      end else if (group_pos == 2'd2) begin
        owe({carry_bits[3:0], v[5:2]}, 1'b1, last, 1'b0);
        carry_bits = {4'b0000, v[1:0]};
        group_pos  = 2'd3;
      end else begin
        owe({carry_bits[1:0], v[5:0]}, 1'b1, last, 1'b0);
        carry_bits = '0;
        group_pos  = 2'd0;
      end
      // bare end marker when the last item gave nothing
      if (last && owed_results.size() == made) begin
        owe(8'h00, 1'b0, 1'b1, 1'b0);
      end
    end
    if (last) begin
      carry_bits = '0;
      group_pos  = 2'd0;
    end
  endtask

  task automatic compare_field(input string label, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual symbol %0h", $time,
               out_symbol_i);
      mismatches++;
    end else begin
      want = owed_results.pop_front();
      compare_field("out_symbol", want.symbol, out_symbol_i);
      compare_field("out_valid", 8'(want.valid), 8'(out_valid_i));
      compare_field("out_last", 8'(want.last), 8'(out_last_i));
      compare_field("out_error", 8'(want.error), 8'(out_error_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = ModeEncode;
      carry_bits   = '0;
      group_pos    = '0;
      mismatches   = 0;
      owed_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results first so a spurious one never meets an expectation from this edge
      if (res_valid_i && !res_stall_i) begin
        check_result();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q     = cfg_data_i;
        carry_bits = '0;
        group_pos  = '0;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_codec_results(in_symbol_i, in_last_i);
      end
      pending_o    <= owed_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import b64sc_pkg::*;

  // cycles with no transfer on any channel before the run is given up
  localparam int WatchdogLimit = 4000;
  // settle time after the last result, covers items still queued with no result
  localparam int DrainCycles = 20;

  string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic       cfg_data    = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] in_symbol   = 8'h00;
  logic       in_last     = 1'b0;
  logic       res_stall   = 1'b0;

  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       res_valid_o;
  logic [7:0] out_symbol_o;
  logic       out_valid_o;
  logic       out_last_o;
  logic       out_error_o;

  int         pending;
  int         fail_count;

  // idle rates in percent, changed per phase of the run
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  logic       cur_mode     = ModeEncode;
  int         items_sent   = 0;

  base64_stream_codec_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .in_symbol_i  (in_symbol),
    .in_last_i    (in_last),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall),
    .out_symbol_o (out_symbol_o),
    .out_valid_o  (out_valid_o),
    .out_last_o   (out_last_o),
    .out_error_o  (out_error_o)
  );

  codec_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .in_symbol_i  (in_symbol),
    .in_last_i    (in_last),
    .res_valid_i  (res_valid_o),
    .res_stall_i  (res_stall),
    .out_symbol_i (out_symbol_o),
    .out_valid_i  (out_valid_o),
    .out_last_i   (out_last_o),
    .out_error_i  (out_error_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    res_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // one input transfer; valid stays high into the next item unless a gap is drawn
  task automatic send_item(input logic [7:0] sym, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // a whole decode stream given as text, last flag on its final character
  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      send_item(s[k], k == s.len() - 1);
    end
  endtask

  // sender holds off until every owed result is back, then the mode write
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    cur_mode  = m;
  endtask

  task automatic random_stream();
    int len;
    int pads;
    if (cur_mode == ModeEncode) begin
      // raw bytes, every flush length shows up
      len = $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
        send_item(8'($urandom_range(255)), k == len - 1);
      end
    end else if ($urandom_range(99) < 80) begin
      // well-formed text: alphabet characters, optional padding at the end
      len  = $urandom_range(1, 12);
      pads = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        send_item(b64_digits[$urandom_range(63)], pads == 0 && k == len - 1);
      end
      for (int p = 0; p < pads; p++) begin
        send_item(CharPad, p == pads - 1);
      end
    end else begin
      // noise: any byte at all, mostly outside the alphabet
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        send_item(8'($urandom_range(255)), k == len - 1);
      end
    end
  endtask

  // gives up when nothing moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (res_valid_o && !res_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 36;
    rcv_idle_pct = 49;

    // encode: one, two, three and five byte streams, so both pad forms and
    // a clean group end; 0xFB 0xFF 0xBF maps onto '+' and '/'
    write_mode(ModeEncode);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hBF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h11, 1'b0);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'h44, 1'b1);

    // decode: padded text with last on '=', full group ending on last,
    // bad characters mid-stream and on last, last with nothing pending
    // (bare end marker), and a lone '=' as the whole stream
    write_mode(ModeDecode);
    send_text("TWE=");
    send_text("/+9a");
    send_item("Q", 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("Z0");
    send_text("A");
    send_item(8'h00, 1'b1);
    send_text("=");

    for (int ph = 0; ph < 3; ph++) begin
      // receiver-heavy gaps, then sender-heavy, then full rate both ways
      case (ph)
        0: begin
          snd_idle_pct = 36;
          rcv_idle_pct = 49;
        end
        1: begin
          snd_idle_pct = 49;
          rcv_idle_pct = 36;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      while (items_sent < 70 * (ph + 1)) begin
        if ($urandom_range(3) == 0) begin
          write_mode(1'($urandom_range(1)));
        end
        random_stream();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
